// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers shared by the feeder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define IWSF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when cond holds, then must hold in the next cycle
`define IWSF_ASSERT_NEXT(lbl, clk, rst, cond, then, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (then)) else $error(msg);

`else

`define IWSF_ASSERT(lbl, clk, rst, prop, msg)
`define IWSF_ASSERT_NEXT(lbl, clk, rst, cond, then, msg)

`endif

`endif

// File: src/iwsf_pkg.sv
// ----------------------------------------------------------------------------
// iwsf_pkg
// types and codes for the i2c write stream feeder
// ----------------------------------------------------------------------------
package iwsf_pkg;

   // request codes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_EVENT = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   // a popped byte with this bit set carries a hold count in bits 7..2
   localparam int unsigned HOLD_BIT = 1;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ADDR   = 2'd1,
      PH_STREAM = 2'd2
   } phase_type;

endpackage

// File: src/iwsf_ring.sv
// ----------------------------------------------------------------------------
// iwsf_ring
// ring byte storage, one write and one registered read port with bypass
// ----------------------------------------------------------------------------
module iwsf_ring #(
   parameter int RING_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
   output logic [7:0]                    rd_data
);

   logic [7:0] mem [RING_DEPTH];
   logic [7:0] mem_q_ff;
   logic       byp_ff;
   logic       byp_in;
   logic [7:0] byp_data_ff;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff    <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   // a load into the slot being fetched shows up here instead of the old word
   assign rd_data = byp_ff ? byp_data_ff : mem_q_ff;

endmodule

// File: src/iwsf_ctrl.sv
// ----------------------------------------------------------------------------
// iwsf_ctrl
// request register, ring pointers, sequence state and response register
// ----------------------------------------------------------------------------
module iwsf_ctrl
   import iwsf_pkg::*;
#(
   parameter int RING_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [7:0]                    req_data_byte,
   input  logic [6:0]                    req_address,
   output logic                          ring_wr_en,
   output logic [$clog2(RING_DEPTH)-1:0] ring_wr_addr,
   output logic [7:0]                    ring_wr_data,
   output logic [$clog2(RING_DEPTH)-1:0] ring_rd_addr,
   input  logic [7:0]                    ring_rd_data,
   output logic                          rsp_valid,
   output logic                          rsp_accepted,
   output logic                          rsp_send_valid,
   output logic [7:0]                    rsp_send_byte,
   output logic                          rsp_pending,
   output logic                          rsp_busy_res
);

   localparam int IdxW = $clog2(RING_DEPTH);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);

   // request register
   logic       in_vld_ff;
   logic [1:0] in_mode_ff;
   logic [7:0] in_data_ff;
   logic [6:0] in_addr_ff;

   // feeder state
   logic [IdxW-1:0] wr_idx_ff, wr_idx_in;
   logic [IdxW-1:0] rd_idx_ff, rd_idx_in;
   logic [IdxW-1:0] wr_nx, rd_nx;
   logic [7:0]      cur_ff, cur_in;
   logic [5:0]      hold_ff, hold_in;
   logic [6:0]      addr_ff, addr_in;
   phase_type       phase_ff, phase_in;

   // response register
   logic       out_vld_ff;
   logic       out_acc_ff, out_acc_in;
   logic       out_sv_ff, out_sv_in;
   logic [7:0] out_sb_ff, out_sb_in;
   logic       out_pend_ff;
   logic       out_busy_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
      in_mode_ff <= req_mode;
      in_data_ff <= req_data_byte;
      in_addr_ff <= req_address;
   end

   assign wr_nx = (wr_idx_ff == LastIdx) ? '0 : wr_idx_ff + 1'b1;
   assign rd_nx = (rd_idx_ff == LastIdx) ? '0 : rd_idx_ff + 1'b1;

   always_comb begin
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      cur_in     = cur_ff;
      hold_in    = hold_ff;
      addr_in    = addr_ff;
      phase_in   = phase_ff;
      out_acc_in = 1'b0;
      out_sv_in  = 1'b0;
      out_sb_in  = 8'd0;
      ring_wr_en = 1'b0;
      if (in_vld_ff) begin
         case (in_mode_ff)
            MODE_LOAD: begin
               // one slot stays free so full and empty differ
               if (wr_nx != rd_idx_ff) begin
                  ring_wr_en = 1'b1;
                  wr_idx_in  = wr_nx;
                  out_acc_in = 1'b1;
               end
            end
            MODE_START: begin
               addr_in  = in_addr_ff;
               phase_in = PH_ADDR;
            end
            MODE_EVENT: begin
               case (phase_ff)
                  PH_ADDR: begin
                     out_sb_in = {addr_ff, 1'b0};
                     out_sv_in = 1'b1;
                     phase_in  = PH_STREAM;
                  end
                  PH_STREAM: begin
                     if (hold_ff == 6'd0) begin
                        if (rd_idx_ff != wr_idx_ff) begin
                           rd_idx_in = rd_nx;
                           if (ring_rd_data[HOLD_BIT]) begin
                              hold_in = ring_rd_data[7:2];
                           end else begin
                              cur_in = ring_rd_data;
                           end
                        end
                     end else begin
                        hold_in = hold_ff - 6'd1;
                     end
                     out_sb_in = cur_in;
                     out_sv_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   assign ring_wr_addr = wr_idx_ff;
   assign ring_wr_data = in_data_ff;
   // prefetch the slot the next pop will read
   assign ring_rd_addr = rd_idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff  <= '0;
         rd_idx_ff  <= '0;
         cur_ff     <= 8'd0;
         hold_ff    <= 6'd0;
         addr_ff    <= 7'd0;
         phase_ff   <= PH_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         wr_idx_ff  <= wr_idx_in;
         rd_idx_ff  <= rd_idx_in;
         cur_ff     <= cur_in;
         hold_ff    <= hold_in;
         addr_ff    <= addr_in;
         phase_ff   <= phase_in;
         out_vld_ff <= in_vld_ff;
      end
      out_acc_ff  <= out_acc_in;
      out_sv_ff   <= out_sv_in;
      out_sb_ff   <= out_sb_in;
      out_pend_ff <= rd_idx_in != wr_idx_in;
      out_busy_ff <= phase_in != PH_IDLE;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_accepted   = out_acc_ff;
   assign rsp_send_valid = out_sv_ff;
   assign rsp_send_byte  = out_sb_ff;
   assign rsp_pending    = out_pend_ff;
   assign rsp_busy_res   = out_busy_ff;

endmodule

// File: src/i2c_write_stream_feeder_with_hold_unit.sv
// ----------------------------------------------------------------------------
// i2c_write_stream_feeder_with_hold_unit
// byte ring feeding an i2c write stream, with address phase and hold counts
// ----------------------------------------------------------------------------
// A request is taken at every clock edge where start is high and busy is low;
// busy is high only while reset is asserted, so one request can be issued
// every cycle. Each request gives exactly one response, in request order. The
// response goes onto the rsp_ ports with rsp_valid high at the clock edge
// after the request edge, stays there for that single cycle and is taken at
// the edge that follows. The response cannot be held off. A request passes
// through the request register and then the response register, with the
// request logic between them; the ring entry for the next pop is fetched ahead
// from the ring memory's single registered read port, with a bypass for a
// load into that same slot. The ring holds RING_DEPTH-1 bytes and needs no
// clearing after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_write_stream_feeder_with_hold_unit
   import iwsf_pkg::*;
#(
   parameter int RING_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data_byte,
   input  logic [6:0] req_address,
   output logic       rsp_valid,
   output logic       rsp_accepted,
   output logic       rsp_send_valid,
   output logic [7:0] rsp_send_byte,
   output logic       rsp_pending,
   output logic       rsp_busy_res
);

   localparam int IdxW = $clog2(RING_DEPTH);

   logic            ring_wr_en;
   logic [IdxW-1:0] ring_wr_addr;
   logic [7:0]      ring_wr_data;
   logic [IdxW-1:0] ring_rd_addr;
   logic [7:0]      ring_rd_data;

   iwsf_ctrl #(
      .RING_DEPTH(RING_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .req_address   (req_address),
      .ring_wr_en    (ring_wr_en),
      .ring_wr_addr  (ring_wr_addr),
      .ring_wr_data  (ring_wr_data),
      .ring_rd_addr  (ring_rd_addr),
      .ring_rd_data  (ring_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_accepted  (rsp_accepted),
      .rsp_send_valid(rsp_send_valid),
      .rsp_send_byte (rsp_send_byte),
      .rsp_pending   (rsp_pending),
      .rsp_busy_res  (rsp_busy_res)
   );

   iwsf_ring #(
      .RING_DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (ring_wr_en),
      .wr_addr(ring_wr_addr),
      .wr_data(ring_wr_data),
      .rd_addr(ring_rd_addr),
      .rd_data(ring_rd_data)
   );

   // a stored byte always leaves the ring non-empty
   `IWSF_ASSERT(a_load_pending, clock, reset, !(rsp_valid && rsp_accepted) || rsp_pending, "load stored but ring reported empty")
   // a transmitted byte only goes out once a sequence is started
   `IWSF_ASSERT(a_send_busy, clock, reset, !(rsp_valid && rsp_send_valid) || rsp_busy_res, "byte sent outside a write sequence")
   // a load never sends and an event never stores
   `IWSF_ASSERT(a_no_mixed, clock, reset, !(rsp_accepted && rsp_send_valid), "response both stored and sent")
   // a ring write is driven from the request register, its response in the next cycle
   `IWSF_ASSERT_NEXT(a_wr_rsp, clock, reset, ring_wr_en, rsp_valid && rsp_accepted, "ring write without stored response")

endmodule
